[rtl/adcvm_pkg.sv]
// Package: shared constants and helpers for the ADC voltmeter display block.
`timescale 1ns / 1ps
`default_nettype none
package adcvm_pkg;

  // Request kinds carried in the func flag
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Converter channels
  localparam logic CH_RAW  = 1'b0;
  localparam logic CH_VOLT = 1'b1;

  // floor(100*x/51) == (x * SCALE_MUL) >> SCALE_SHIFT for every 8-bit x
  localparam int unsigned SCALE_SHIFT = 16;
  localparam logic [16:0] SCALE_MUL   = 17'd128502;

  // n / 10 == (n * DIV10_MUL) >> DIV10_SHIFT for n below 100
  localparam int unsigned DIV10_SHIFT = 11;
  localparam logic [7:0]  DIV10_MUL   = 8'd205;

  localparam logic       DP_BIT = 1'b1;

  // One-hot digit enables
  localparam logic [2:0] EN_NONE     = 3'b000;
  localparam logic [2:0] EN_HUNDREDS = 3'b001;
  localparam logic [2:0] EN_TENS     = 3'b010;
  localparam logic [2:0] EN_UNITS    = 3'b100;

  typedef enum logic [1:0] {
    POS_HUNDREDS = 2'd0,
    POS_TENS     = 2'd1,
    POS_UNITS    = 2'd2,
    POS_UNUSED   = 2'd3
  } scan_pos_t;

  // Common-cathode pattern, bits 6..0 are segments g..a
  function automatic logic [6:0] encode_digit(input logic [3:0] d);
    logic [6:0] seg;
    case (d)
      4'd0:    seg = 7'b0111111;
      4'd1:    seg = 7'b0000110;
      4'd2:    seg = 7'b1011011;
      4'd3:    seg = 7'b1001111;
      4'd4:    seg = 7'b1100110;
      4'd5:    seg = 7'b1101101;
      4'd6:    seg = 7'b1111101;
      4'd7:    seg = 7'b0000111;
      4'd8:    seg = 7'b1111111;
      4'd9:    seg = 7'b1101111;
      default: seg = 7'b0000000;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

[rtl/adc_voltmeter_seven_segment_scan.sv]
// Top level: ADC voltmeter with raw-level output and three-digit display scan.
// Each request is a converter sample (tuser[0] low) or a scan tick (tuser[0] high).
// A channel-0 sample sets raw_level; a channel-1 sample sets the shown voltage
// to floor(100*sample/51). Each tick drives the next digit, hundreds (with
// decimal point), tens, units, and returns one result per request. The block
// takes one request per cycle while the result side keeps up. Each request
// lands in the input register, then one pass of scaling, digit split and
// segment encoding fills the result register once that register is free or
// being read. A result held off by out_tready stalls the input once both
// registers are full.
`timescale 1ns / 1ps
`default_nettype none
module adc_voltmeter_seven_segment_scan (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] sample
  input  wire logic [1:0]  in_tuser,   // [0] func, [1] channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [7:0] segments, [10:8] digit_enable,
                                       // [18:11] raw_level, [23:19] zero
);

  // Input register
  logic       in_v_r;
  logic       func_r;
  logic       chan_r;
  logic [7:0] sample_r;

  // Block state
  logic [8:0]             scaled_r;
  logic [7:0]             raw_r;
  adcvm_pkg::scan_pos_t   pos_r;
  logic [7:0]             seg_r;
  logic [2:0]             en_r;

  // Result register
  logic        out_v_r;
  logic [18:0] out_data_r;

  logic fire;

  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  // Scaling of the incoming sample
  logic [24:0] scale_prod;
  logic [8:0]  scaled_nxt;

  assign scale_prod = {17'd0, sample_r} * {8'd0, adcvm_pkg::SCALE_MUL};
  assign scaled_nxt = scale_prod[adcvm_pkg::SCALE_SHIFT +: 9];

  // Digit split of the held value
  logic [3:0]  hundreds;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  units;

  always_comb begin
    hundreds = 4'd0;
    rem      = scaled_r[6:0];
    if (scaled_r >= 9'd500) begin
      hundreds = 4'd5;
      rem      = 7'(scaled_r - 9'd500);
    end else if (scaled_r >= 9'd400) begin
      hundreds = 4'd4;
      rem      = 7'(scaled_r - 9'd400);
    end else if (scaled_r >= 9'd300) begin
      hundreds = 4'd3;
      rem      = 7'(scaled_r - 9'd300);
    end else if (scaled_r >= 9'd200) begin
      hundreds = 4'd2;
      rem      = 7'(scaled_r - 9'd200);
    end else if (scaled_r >= 9'd100) begin
      hundreds = 4'd1;
      rem      = 7'(scaled_r - 9'd100);
    end
  end

  assign tens_prod = {8'd0, rem} * {7'd0, adcvm_pkg::DIV10_MUL};
  assign tens      = tens_prod[adcvm_pkg::DIV10_SHIFT +: 4];
  assign units     = 4'(rem - 7'({3'd0, tens} * 7'd10));

  // Next state
  logic [8:0]           scaled_nxt_s;
  logic [7:0]           raw_nxt;
  adcvm_pkg::scan_pos_t pos_nxt;
  logic [7:0]           seg_nxt;
  logic [2:0]           en_nxt;

  always_comb begin
    scaled_nxt_s = scaled_r;
    raw_nxt      = raw_r;
    pos_nxt      = pos_r;
    seg_nxt      = seg_r;
    en_nxt       = en_r;
    if (func_r == adcvm_pkg::FUNC_SAMPLE) begin
      if (chan_r == adcvm_pkg::CH_RAW) begin
        raw_nxt = sample_r;
      end else begin
        scaled_nxt_s = scaled_nxt;
      end
    end else begin
      case (pos_r)
        adcvm_pkg::POS_HUNDREDS: begin
          seg_nxt = {adcvm_pkg::DP_BIT, adcvm_pkg::encode_digit(hundreds)};
          en_nxt  = adcvm_pkg::EN_HUNDREDS;
          pos_nxt = adcvm_pkg::POS_TENS;
        end
        adcvm_pkg::POS_TENS: begin
          seg_nxt = {1'b0, adcvm_pkg::encode_digit(tens)};
          en_nxt  = adcvm_pkg::EN_TENS;
          pos_nxt = adcvm_pkg::POS_UNITS;
        end
        adcvm_pkg::POS_UNITS: begin
          seg_nxt = {1'b0, adcvm_pkg::encode_digit(units)};
          en_nxt  = adcvm_pkg::EN_UNITS;
          pos_nxt = adcvm_pkg::POS_HUNDREDS;
        end
        default: begin
          // Unused position: blank the enable, hold the pattern
          en_nxt  = adcvm_pkg::EN_NONE;
          pos_nxt = adcvm_pkg::POS_HUNDREDS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      scaled_r <= 9'd0;
      raw_r    <= 8'd0;
      pos_r    <= adcvm_pkg::POS_HUNDREDS;
      seg_r    <= 8'd0;
      en_r     <= adcvm_pkg::EN_NONE;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (fire) begin
        out_v_r  <= 1'b1;
        scaled_r <= scaled_nxt_s;
        raw_r    <= raw_nxt;
        pos_r    <= pos_nxt;
        seg_r    <= seg_nxt;
        en_r     <= en_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r   <= in_tuser[0];
      chan_r   <= in_tuser[1];
      sample_r <= in_tdata;
    end
    if (fire) begin
      out_data_r <= {raw_nxt, en_nxt, seg_nxt};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_data_r};

endmodule
`default_nettype wire

[tb/sv/tb_adc_voltmeter_seven_segment_scan.sv]
// Testbench for the voltmeter display scan: random and directed requests, results checked in order.
`timescale 1ns / 1ps
module tb_adc_voltmeter_seven_segment_scan;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 220;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam logic [7:0] VOLT_POINTS [4] = '{8'd1, 8'd51, 8'd128, 8'd254};
  localparam int unsigned IDLE_PLAN [4] = '{0, 63, 0, 36};
  localparam int unsigned STALL_PLAN [4] = '{0, 0, 63, 36};

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] digit_enable;
    logic [7:0] raw_level;
  } display_t;

  class voltmeter_scoreboard;
    display_t             display_q[$];
    logic [8:0]           centivolts;
    logic [7:0]           raw_latch;
    adcvm_pkg::scan_pos_t next_digit;
    logic [7:0]           seg_latch;
    logic [2:0]           en_latch;
    int                   mismatches;

    function new();
      centivolts = '0;
      raw_latch  = '0;
      next_digit = adcvm_pkg::POS_HUNDREDS;
      seg_latch  = '0;
      en_latch   = adcvm_pkg::EN_NONE;
      mismatches = 0;
    endfunction

    // Common-cathode patterns, bit 7 left clear
    function logic [7:0] digit_segments(int unsigned d);
      case (d)
        0: return 8'h3F;
        1: return 8'h06;
        2: return 8'h5B;
        3: return 8'h4F;
        4: return 8'h66;
        5: return 8'h6D;
        6: return 8'h7D;
        7: return 8'h07;
        8: return 8'h7F;
        9: return 8'h6F;
        default: return 8'h00;
      endcase
    endfunction

    function void note_request(logic func, logic channel, logic [7:0] sample);
      display_t shown;
      if (func == adcvm_pkg::FUNC_SAMPLE) begin
        if (channel == adcvm_pkg::CH_RAW) begin
          raw_latch = sample;
        end else begin
          centivolts = 9'((100 * int'(sample)) / 51);
        end
      end else begin
        case (next_digit)
          adcvm_pkg::POS_HUNDREDS: begin
            seg_latch    = digit_segments(centivolts / 100);
            seg_latch[7] = adcvm_pkg::DP_BIT;
            en_latch     = adcvm_pkg::EN_HUNDREDS;
            next_digit   = adcvm_pkg::POS_TENS;
          end
          adcvm_pkg::POS_TENS: begin
            seg_latch  = digit_segments((centivolts / 10) % 10);
            en_latch   = adcvm_pkg::EN_TENS;
            next_digit = adcvm_pkg::POS_UNITS;
          end
          adcvm_pkg::POS_UNITS: begin
            seg_latch  = digit_segments(centivolts % 10);
            en_latch   = adcvm_pkg::EN_UNITS;
            next_digit = adcvm_pkg::POS_HUNDREDS;
          end
          default: begin
            // unused position: blank the enable, keep the pattern
            en_latch   = adcvm_pkg::EN_NONE;
            next_digit = adcvm_pkg::POS_HUNDREDS;
          end
        endcase
      end
      shown.segments     = seg_latch;
      shown.digit_enable = en_latch;
      shown.raw_level    = raw_latch;
      display_q.push_back(shown);
    endfunction

    task check_result(logic [23:0] data);
      display_t want;
      if (display_q.size() == 0) begin
        report("result with no request outstanding", data[7:0], 8'h00);
        return;
      end
      want = display_q.pop_front();
      if (data[7:0] !== want.segments)
        report("segments", data[7:0], want.segments);
      if (data[10:8] !== want.digit_enable)
        report("digit_enable", 8'(data[10:8]), 8'(want.digit_enable));
      if (data[18:11] !== want.raw_level)
        report("raw_level", data[18:11], want.raw_level);
    endtask

    task report(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] sample
  logic [1:0]  in_tuser = '0;   // [0] func, [1] channel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] segments, [10:8] digit_enable, [18:11] raw_level

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;

  voltmeter_scoreboard board = new();

  adc_voltmeter_seven_segment_scan i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.note_request(in_tuser[0], in_tuser[1], in_tdata);
      if (out_tvalid && out_tready)
        board.check_result(out_tdata);
    end
  end

  // Result side: random stalls, or a long hold-off when one is asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Offer one request and hold it until taken
  task send_request(logic func, logic channel, logic [7:0] sample);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {channel, func};
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
  endtask

  task send_random();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 50)
      send_request(adcvm_pkg::FUNC_TICK, 1'($urandom), 8'($urandom));
    else if (pick < 75)
      send_request(adcvm_pkg::FUNC_SAMPLE, adcvm_pkg::CH_RAW, 8'($urandom));
    else
      send_request(adcvm_pkg::FUNC_SAMPLE, adcvm_pkg::CH_VOLT, 8'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sample before any tick: nothing enabled yet
    send_request(adcvm_pkg::FUNC_SAMPLE, adcvm_pkg::CH_RAW, 8'h00);
    // Scan the reset voltage; channel and sample on a tick are don't-cares
    send_request(adcvm_pkg::FUNC_TICK, adcvm_pkg::CH_VOLT, 8'hFF);
    send_request(adcvm_pkg::FUNC_TICK, adcvm_pkg::CH_RAW, 8'h00);
    send_request(adcvm_pkg::FUNC_TICK, adcvm_pkg::CH_VOLT, 8'hA5);
    send_request(adcvm_pkg::FUNC_SAMPLE, adcvm_pkg::CH_RAW, 8'hFF);
    // Full scale reads 5.00
    send_request(adcvm_pkg::FUNC_SAMPLE, adcvm_pkg::CH_VOLT, 8'hFF);
    send_request(adcvm_pkg::FUNC_TICK, adcvm_pkg::CH_RAW, 8'hFF);
    send_request(adcvm_pkg::FUNC_TICK, adcvm_pkg::CH_VOLT, 8'h00);
    send_request(adcvm_pkg::FUNC_TICK, adcvm_pkg::CH_RAW, 8'h5A);
    foreach (VOLT_POINTS[i]) begin
      send_request(adcvm_pkg::FUNC_SAMPLE, adcvm_pkg::CH_VOLT, VOLT_POINTS[i]);
      repeat (3) send_request(adcvm_pkg::FUNC_TICK, 1'($urandom), 8'($urandom));
    end

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = IDLE_PLAN[phase];
      stall_pct = STALL_PLAN[phase];
      repeat (PHASE_ITEMS) send_random();
    end

    // Hold the result side off while requests keep coming, so the block backs up
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (60) send_random();
    in_tvalid <= 1'b0;

    while (board.display_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[adc_voltmeter_seven_segment_scan.f]
rtl/adcvm_pkg.sv
rtl/adc_voltmeter_seven_segment_scan.sv
tb/sv/tb_adc_voltmeter_seven_segment_scan.sv
